[rtl/core/omc_pkg.sv]
`default_nettype none

package omc_pkg;

    localparam int WEIGHT_W      = 32;
    localparam int ENTRY_W       = 48;
    localparam int COST_W        = 64;
    localparam int MAX_ITEMS_DEF = 1024;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_MERGE
    } cell_op_t;

    // Broadcast to every cell of the chain.
    typedef struct packed {
        cell_op_t              op;
        logic [ENTRY_W-1:0]    key;
    } cell_ctl_t;

    // What a cell shows to its neighbors.
    typedef struct packed {
        logic                  le;
        logic [ENTRY_W-1:0]    val;
    } cell_link_t;

endpackage

`default_nettype wire

[rtl/core/omc_cell.sv]
`default_nettype none

module omc_cell
    import omc_pkg::*;
#(
    parameter int IDX   = 0,
    parameter int CNT_W = 11
)
(
    input  wire logic             clk,
    input  wire cell_ctl_t        ctl,
    input  wire logic [CNT_W-1:0] count,
    input  wire cell_link_t       prev_link,
    input  wire cell_link_t       next1_link,
    input  wire cell_link_t       next2_link,
    output cell_link_t            link
);

    logic [ENTRY_W-1:0] val_reg;
    logic [ENTRY_W-1:0] val_next;
    logic               le_self;

    // The chain is sorted ascending, so the cells that hold a value no larger
    // than the key form a prefix of the occupied cells.
    assign le_self = (count > CNT_W'(IDX)) && (val_reg <= ctl.key);
    assign link.le  = le_self;
    assign link.val = val_reg;

    always_comb
    begin
        case (ctl.op)
            CELL_INSERT:
            begin
                if (le_self)
                    val_next = val_reg;
                else if (prev_link.le)
                    val_next = ctl.key;
                else
                    val_next = prev_link.val;
            end
            // Drop the two front entries and slide the key into place in one step.
            CELL_MERGE:
            begin
                if (next2_link.le)
                    val_next = next2_link.val;
                else if (next1_link.le)
                    val_next = ctl.key;
                else
                    val_next = next1_link.val;
            end
            default:
                val_next = val_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

endmodule

`default_nettype wire

[rtl/core/optimal_merge_cost_core.sv]
`default_nettype none

// Optimal merge (Huffman) cost of a set of weights. Weights arrive one item per
// cycle while the block is in S_LOAD and are kept in a sorted chain of MAX_ITEMS
// cells; weights that arrive once the chain is full are dropped. The item with
// last set closes the set: the block then merges the n kept weights pairwise,
// each merge adding the two front cells in S_SUM and then, in S_MERGE, letting
// the chain drop them and slide the sum into place; S_DONE then loads the result
// register, which waits for as long as a previous result is still stalled.
// total_cost is 0 for a set of one weight. The block takes no input item while
// it merges, and takes the next set as soon as the result is registered, even
// if it has not yet been taken.
module optimal_merge_cost_core
    import omc_pkg::*;
#(
    parameter int MAX_ITEMS = MAX_ITEMS_DEF
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                item_valid,
    output logic                     item_stall,
    input  wire logic [WEIGHT_W-1:0] weight,
    input  wire logic                last,
    output logic                     result_valid,
    input  wire logic                result_stall,
    output logic [COST_W-1:0]        total_cost
);

    localparam int CNT_W = $clog2(MAX_ITEMS + 1);

    typedef enum logic [1:0] {
        S_LOAD,
        S_SUM,
        S_MERGE,
        S_DONE
    } state_t;

    state_t             state_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [ENTRY_W-1:0] sum_reg;
    logic [COST_W-1:0]  cost_reg;
    logic               result_valid_reg;
    logic [COST_W-1:0]  total_cost_reg;

    logic               room;
    cell_ctl_t          ctl;
    cell_link_t         link [MAX_ITEMS];

    assign room         = (count_reg != CNT_W'(MAX_ITEMS));
    assign item_stall   = (state_reg != S_LOAD);
    assign result_valid = result_valid_reg;
    assign total_cost   = total_cost_reg;

    always_comb
    begin
        ctl.op  = CELL_HOLD;
        ctl.key = sum_reg;
        if (state_reg == S_LOAD)
        begin
            ctl.key = {{(ENTRY_W-WEIGHT_W){1'b0}}, weight};
            if (item_valid && room)
                ctl.op = CELL_INSERT;
        end
        else if (state_reg == S_MERGE)
        begin
            ctl.op = CELL_MERGE;
        end
    end

    for (genvar i = 0; i < MAX_ITEMS; i++)
    begin : g_cell
        cell_link_t prev_l;
        cell_link_t next1_l;
        cell_link_t next2_l;

        // The front cell sees an imaginary neighbor that is never larger than the key.
        if (i == 0)
        begin : g_front
            assign prev_l = '{le: 1'b1, val: '0};
        end
        else
        begin : g_mid
            assign prev_l = link[i-1];
        end

        if (i + 1 < MAX_ITEMS)
        begin : g_n1
            assign next1_l = link[i+1];
        end
        else
        begin : g_n1_end
            assign next1_l = '0;
        end

        if (i + 2 < MAX_ITEMS)
        begin : g_n2
            assign next2_l = link[i+2];
        end
        else
        begin : g_n2_end
            assign next2_l = '0;
        end

        omc_cell #(
            .IDX   (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .count      (count_reg),
            .prev_link  (prev_l),
            .next1_link (next1_l),
            .next2_link (next2_l),
            .link       (link[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_LOAD;
            count_reg        <= '0;
            sum_reg          <= '0;
            cost_reg         <= '0;
            result_valid_reg <= 1'b0;
            total_cost_reg   <= '0;
        end
        else
        begin
            // The result stage handles the output register on its own.
            if (result_valid_reg && !result_stall && state_reg != S_DONE)
                result_valid_reg <= 1'b0;

            case (state_reg)
                S_LOAD:
                begin
                    if (item_valid)
                    begin
                        if (room)
                            count_reg <= count_reg + CNT_W'(1);
                        if (last)
                        begin
                            cost_reg <= '0;
                            // With at least two cells, one occupied cell plus this item merges.
                            if (count_reg != '0)
                                state_reg <= S_SUM;
                            else
                                state_reg <= S_DONE;
                        end
                    end
                end
                S_SUM:
                begin
                    sum_reg   <= link[0].val + link[1].val;
                    state_reg <= S_MERGE;
                end
                S_MERGE:
                begin
                    cost_reg  <= cost_reg + {{(COST_W-ENTRY_W){1'b0}}, sum_reg};
                    count_reg <= count_reg - CNT_W'(1);
                    if (count_reg == CNT_W'(2))
                        state_reg <= S_DONE;
                    else
                        state_reg <= S_SUM;
                end
                S_DONE:
                begin
                    if (!result_valid_reg || !result_stall)
                    begin
                        result_valid_reg <= 1'b1;
                        total_cost_reg   <= cost_reg;
                        count_reg        <= '0;
                        state_reg        <= S_LOAD;
                    end
                end
                default:
                    state_reg <= S_LOAD;
            endcase
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_ITEMS))
        else $error("cell count above chain length");

    a_front_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg >= CNT_W'(2)) |-> (link[0].val <= link[1].val))
        else $error("front of chain out of order");

    a_merge_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MERGE) |=> (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("merge did not remove exactly one entry");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) |-> (count_reg == CNT_W'(1)))
        else $error("result stage reached with more or less than one entry");

endmodule

`default_nettype wire

[test/optimal_merge_cost_core_test.sv]
`timescale 1ns / 100ps

module optimal_merge_cost_core_test;
    import omc_pkg::*;

    localparam int MAX_KEPT    = MAX_ITEMS_DEF;
    localparam int STALL_LIMIT = 20000;
    localparam int RAND_ITEMS  = 950;
    localparam int DRAIN_WAIT  = 40;
    localparam bit TYPED       = 1'b1;
    localparam bit PREDICTED   = 1'b0;

    typedef enum int {
        PACE_SLOW_SINK,
        PACE_SLOW_SOURCE,
        PACE_FULL
    } pace_t;

    typedef enum int {
        WEIGHT_ANY,
        WEIGHT_TINY,
        WEIGHT_NEAR_MAX
    } weight_style_t;

    typedef struct packed {
        logic [WEIGHT_W-1:0] weight;
        logic                last;
        logic                typed;
        logic [COST_W-1:0]   cost;
    } set_row_t;

    logic                clk;
    logic                rst_n;
    logic                item_valid;
    logic                item_stall;
    logic [WEIGHT_W-1:0] weight;
    logic                last;
    logic                result_valid;
    logic                result_stall;
    logic [COST_W-1:0]   total_cost;

    // Travels with the item so that the checker knows whether a typed cost applies.
    logic                item_typed;
    logic [COST_W-1:0]   item_cost;

    pace_t               pace;
    logic [ENTRY_W-1:0]  held_keys[$];
    logic [COST_W-1:0]   cost_due[$];
    int                  fail_count;
    int                  quiet_cycles;
    int                  random_sent;

    set_row_t directed_rows [0:18] = '{
        '{32'd5,          1'b1, TYPED,     64'd0},
        '{32'd0,          1'b1, TYPED,     64'd0},
        '{32'hFFFF_FFFF,  1'b1, TYPED,     64'd0},
        '{32'hFFFF_FFFF,  1'b0, PREDICTED, 64'd0},
        '{32'hFFFF_FFFF,  1'b1, TYPED,     64'h1_FFFF_FFFE},
        '{32'd0,          1'b0, PREDICTED, 64'd0},
        '{32'd0,          1'b1, TYPED,     64'd0},
        '{32'd1,          1'b0, PREDICTED, 64'd0},
        '{32'd2,          1'b0, PREDICTED, 64'd0},
        '{32'd3,          1'b1, TYPED,     64'd9},
        '{32'hFFFF_FFFF,  1'b0, PREDICTED, 64'd0},
        '{32'hFFFF_FFFF,  1'b0, PREDICTED, 64'd0},
        '{32'hFFFF_FFFF,  1'b0, PREDICTED, 64'd0},
        '{32'hFFFF_FFFF,  1'b1, TYPED,     64'h7_FFFF_FFF8},
        '{32'hA5A5_A5A5,  1'b0, PREDICTED, 64'd0},
        '{32'h5A5A_5A5A,  1'b0, PREDICTED, 64'd0},
        '{32'd1,          1'b0, PREDICTED, 64'd0},
        '{32'h8000_0000,  1'b0, PREDICTED, 64'd0},
        '{32'h7FFF_FFFF,  1'b1, PREDICTED, 64'd0}
    };

    optimal_merge_cost_core #(
        .MAX_ITEMS(MAX_KEPT)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .weight(weight),
        .last(last),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .total_cost(total_cost)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Keeps the pending keys in ascending order.
    function automatic void add_sorted(input logic [ENTRY_W-1:0] key);
        int pos;
        pos = 0;
        while (pos < held_keys.size() && held_keys[pos] <= key)
            pos++;
        held_keys.insert(pos, key);
    endfunction

    // Merges the two smallest keys until one is left and returns the summed cost.
    function automatic logic [COST_W-1:0] merge_all();
        logic [ENTRY_W-1:0] a;
        logic [ENTRY_W-1:0] b;
        logic [ENTRY_W-1:0] s;
        logic [COST_W-1:0]  acc;
        acc = '0;
        while (held_keys.size() > 1)
        begin
            a = held_keys.pop_front();
            b = held_keys.pop_front();
            s = a + b;
            acc = acc + {{(COST_W-ENTRY_W){1'b0}}, s};
            add_sorted(s);
        end
        held_keys.delete();
        return acc;
    endfunction

    function automatic logic [WEIGHT_W-1:0] pick_weight(input weight_style_t style);
        case (style)
            WEIGHT_TINY:     return WEIGHT_W'($urandom_range(15));
            WEIGHT_NEAR_MAX: return 32'hFFFF_FFFF - WEIGHT_W'($urandom_range(255));
            default:         return $urandom;
        endcase
    endfunction

    function automatic int sender_idle_pct();
        case (pace)
            PACE_SLOW_SINK:   return 14;
            PACE_SLOW_SOURCE: return 61;
            default:          return 0;
        endcase
    endfunction

    // Called at a rising edge; returns at the rising edge that takes the item.
    task automatic send_item(input logic [WEIGHT_W-1:0] w, input logic l,
                             input logic typed, input logic [COST_W-1:0] cost);
        bit gap;
        gap = ($urandom_range(99) < sender_idle_pct());
        if (gap)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < sender_idle_pct())
                @(posedge clk);
        end
        item_valid <= 1'b1;
        weight     <= w;
        last       <= l;
        item_typed <= typed;
        item_cost  <= cost;
        forever
        begin
            @(negedge clk);
            if (!item_stall)
                break;
        end
        @(posedge clk);
    endtask

    task automatic send_set(input int count, input weight_style_t style);
        for (int i = 0; i < count; i++)
            send_item(pick_weight(style), i == count - 1, PREDICTED, '0);
    endtask

    task automatic wait_results_done();
        while (cost_due.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        case (pace)
            PACE_SLOW_SINK:   result_stall <= ($urandom_range(99) < 61);
            PACE_SLOW_SOURCE: result_stall <= ($urandom_range(99) < 14);
            default:          result_stall <= 1'b0;
        endcase
    end

    // Inputs and outputs only change at rising edges, so values seen here are
    // the ones that the next rising edge takes.
    always @(negedge clk)
    begin
        logic [COST_W-1:0] predicted;
        logic [COST_W-1:0] wanted;
        logic              took;
        took = 1'b0;
        if (rst_n)
        begin
            if (item_valid && !item_stall)
            begin
                took = 1'b1;
                if (held_keys.size() < MAX_KEPT)
                    add_sorted({{(ENTRY_W-WEIGHT_W){1'b0}}, weight});
                if (last)
                begin
                    predicted = merge_all();
                    cost_due.push_back(item_typed ? item_cost : predicted);
                end
            end
            if (result_valid && !result_stall)
            begin
                took = 1'b1;
                if (cost_due.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, got total_cost %h",
                             $time, total_cost);
                    fail_count++;
                end
                else
                begin
                    wanted = cost_due.pop_front();
                    if (total_cost !== wanted)
                    begin
                        $display("%0t: total_cost expected %h, got %h",
                                 $time, wanted, total_cost);
                        fail_count++;
                    end
                end
            end
            quiet_cycles = took ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
                $display("optimal_merge_cost_core_test NOT OK");
                $finish;
            end
        end
    end

    initial
    begin
        int            set_size;
        int            pick;
        weight_style_t style;
        rst_n        = 1'b0;
        item_valid   = 1'b0;
        weight       = '0;
        last         = 1'b0;
        item_typed   = 1'b0;
        item_cost    = '0;
        result_stall = 1'b0;
        pace         = PACE_SLOW_SINK;
        fail_count   = 0;
        quiet_cycles = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_item(directed_rows[i].weight, directed_rows[i].last,
                      directed_rows[i].typed, directed_rows[i].cost);

        // Overfill the chain so that the trailing weights get dropped.
        send_set(MAX_KEPT + 6, WEIGHT_ANY);

        // Hold the next item back until the block has delivered everything.
        item_valid <= 1'b0;
        wait_results_done();
        @(posedge clk);

        random_sent = 0;
        for (int phase = 0; phase < 3; phase++)
        begin
            pace = pace_t'(phase);
            while (random_sent < RAND_ITEMS * (phase + 1) / 3)
            begin
                pick = $urandom_range(99);
                if (pick < 70)
                    set_size = $urandom_range(12, 1);
                else if (pick < 95)
                    set_size = $urandom_range(80, 13);
                else
                    set_size = $urandom_range(300, 81);
                style = weight_style_t'($urandom_range(2));
                send_set(set_size, style);
                random_sent += set_size;
            end
        end

        item_valid <= 1'b0;
        wait_results_done();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (fail_count == 0)
            $display("optimal_merge_cost_core_test OK");
        else
            $display("optimal_merge_cost_core_test NOT OK");
        $finish;
    end

endmodule
